// ----- design/assert_macros.svh -----
// Assertion helpers included by the checker leiq_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define ASSERT_CLK(label, clk_i, rst_ni, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication whose consequent is checked in the next cycle, switched off while reset is held.
`define ASSERT_NEXT(label, clk_i, rst_ni, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/leiq_pkg.sv -----
// ----------------------------------------------------------------------------
// leiq_pkg
// Shared types and character codes for the line editor input queue.
// ----------------------------------------------------------------------------
`default_nettype none

package leiq_pkg;

  localparam int CHAR_W      = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;

  localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

  // request kinds on in_tuser
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture the incoming request
    logic clr_res;     // result: nothing happened
    logic append;      // append char to line, echo it
    logic back;        // drop last char, echo backspace
    logic rd_take;     // pop oldest queue byte at tail (or report empty)
    logic copy_start;  // reset copy counter
    logic copy;        // one step of the line-to-queue copy
    logic newline;     // push LF, clear line, echo LF
    logic post;        // move result to the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_read;
    logic ch_zero;
    logic ch_bs;
    logic ch_nl;
    logic line_empty;
    logic line_full;
    logic copy_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/leiq_ram.sv -----
// ----------------------------------------------------------------------------
// leiq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module leiq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/leiq_ctrl.sv -----
// ----------------------------------------------------------------------------
// leiq_ctrl
// Sequencer: decodes a request and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module leiq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire leiq_pkg::dp_status_t sts,
  output leiq_pkg::ctrl_cmd_t       cmd
);

  import leiq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RDATA,
    S_COPY,
    S_NEWLINE,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_read) begin
          // queue RAM read of the tail is in flight
          state_nxt = S_RDATA;
        end else if (sts.ch_nl) begin
          cmd.copy_start = 1'b1;
          state_nxt      = S_COPY;
        end else if (sts.ch_zero) begin
          cmd.clr_res = 1'b1;
          state_nxt   = S_FINISH;
        end else if (sts.ch_bs) begin
          if (sts.line_empty) cmd.clr_res = 1'b1;
          else                cmd.back    = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          if (sts.line_full) cmd.clr_res = 1'b1;
          else               cmd.append  = 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_RDATA: begin
        cmd.rd_take = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (sts.copy_done) state_nxt = S_NEWLINE;
      end
      S_NEWLINE: begin
        cmd.newline = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.post  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/leiq_dp.sv -----
// ----------------------------------------------------------------------------
// leiq_dp
// Datapath: line buffer, ring queue, pointers, result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module leiq_dp #(
  parameter int LINE_DEPTH  = 1024,
  parameter int QUEUE_DEPTH = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire leiq_pkg::ctrl_cmd_t                 cmd,
  output leiq_pkg::dp_status_t                     sts,
  input  wire logic                                in_tuser,
  input  wire logic [leiq_pkg::CHAR_W-1:0]         in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [leiq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic      [leiq_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  import leiq_pkg::*;

  localparam int LW = $clog2(LINE_DEPTH);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam logic [LW-1:0] LEN_MAX = LW'(LINE_DEPTH - 1);
  localparam logic [QW-1:0] Q_LAST  = QW'(QUEUE_DEPTH - 1);

  function automatic logic [QW-1:0] q_next(input logic [QW-1:0] p);
    return (p == Q_LAST) ? '0 : p + 1'b1;
  endfunction

  // control state
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [QW-1:0] head_r, head_nxt;
  logic [QW-1:0] tail_r, tail_nxt;
  logic          ovld_r, ovld_nxt;

  // payload
  logic              kind_r, kind_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic              ev_r, ev_nxt;
  logic [CHAR_W-1:0] ec_r, ec_nxt;
  logic              rv_r, rv_nxt;
  logic [CHAR_W-1:0] rc_r, rc_nxt;
  logic [OUT_TDATA_W-1:0] odata_r, odata_nxt;
  logic [OUT_TUSER_W-1:0] ouser_r, ouser_nxt;

  // memories
  logic              l_we;
  logic [CHAR_W-1:0] l_rdata;
  logic              q_push;
  logic [CHAR_W-1:0] q_wdata;
  logic              q_we;
  logic [CHAR_W-1:0] q_rdata;

  leiq_ram #(.WIDTH(CHAR_W), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (len_r),
    .wdata (ch_r),
    .raddr (cnt_r),
    .rdata (l_rdata)
  );

  leiq_ram #(.WIDTH(CHAR_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (head_r),
    .wdata (q_wdata),
    .raddr (tail_r),
    .rdata (q_rdata)
  );

  always_comb begin
    sts.is_read    = (kind_r == CMD_READ);
    sts.ch_zero    = (ch_r == CH_NUL);
    sts.ch_bs      = (ch_r == CH_BS);
    sts.ch_nl      = (ch_r == CH_LF) || (ch_r == CH_CR);
    sts.line_empty = (len_r == '0);
    sts.line_full  = (len_r == LEN_MAX);
    sts.copy_done  = (cnt_r == len_r);
    sts.out_free   = !ovld_r || out_tready;
  end

  // a push is dropped when the ring is full
  assign q_we = q_push && (q_next(head_r) != tail_r);

  always_comb begin
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    kind_nxt  = kind_r;
    ch_nxt    = ch_r;
    ev_nxt    = ev_r;
    ec_nxt    = ec_r;
    rv_nxt    = rv_r;
    rc_nxt    = rc_r;
    odata_nxt = odata_r;
    ouser_nxt = ouser_r;
    l_we      = 1'b0;
    q_push    = 1'b0;
    q_wdata   = CH_LF;
    ovld_nxt  = (ovld_r && !out_tready);

    if (cmd.load) begin
      kind_nxt = in_tuser;
      ch_nxt   = in_tdata;
    end
    if (cmd.clr_res) begin
      ev_nxt = 1'b0;
      ec_nxt = CH_NUL;
      rv_nxt = 1'b0;
      rc_nxt = CH_NUL;
    end
    if (cmd.append) begin
      l_we    = 1'b1;
      len_nxt = len_r + 1'b1;
      ev_nxt  = 1'b1;
      ec_nxt  = ch_r;
      rv_nxt  = 1'b0;
      rc_nxt  = CH_NUL;
    end
    if (cmd.back) begin
      len_nxt = len_r - 1'b1;
      ev_nxt  = 1'b1;
      ec_nxt  = CH_BS;
      rv_nxt  = 1'b0;
      rc_nxt  = CH_NUL;
    end
    if (cmd.rd_take) begin
      ev_nxt = 1'b0;
      ec_nxt = CH_NUL;
      if (head_r != tail_r) begin
        rv_nxt   = 1'b1;
        rc_nxt   = q_rdata;
        tail_nxt = q_next(tail_r);
      end else begin
        rv_nxt = 1'b0;
        rc_nxt = CH_NUL;
      end
    end
    if (cmd.copy_start) begin
      cnt_nxt  = '0;
      pend_nxt = 1'b0;
    end
    if (cmd.copy) begin
      // read of cnt_r issued now, data lands next cycle
      if (cnt_r != len_r) begin
        cnt_nxt  = cnt_r + 1'b1;
        pend_nxt = 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
      if (pend_r) begin
        q_push  = 1'b1;
        q_wdata = l_rdata;
      end
    end
    if (cmd.newline) begin
      q_push  = 1'b1;
      q_wdata = CH_LF;
      len_nxt = '0;
      ev_nxt  = 1'b1;
      ec_nxt  = CH_LF;
      rv_nxt  = 1'b0;
      rc_nxt  = CH_NUL;
    end
    if (q_we) begin
      head_nxt = q_next(head_r);
    end
    if (cmd.post) begin
      ovld_nxt  = 1'b1;
      odata_nxt = {rc_r, ec_r};
      ouser_nxt = {rv_r, ev_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
      head_r <= '0;
      tail_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    ch_r    <= ch_nxt;
    ev_r    <= ev_nxt;
    ec_r    <= ec_nxt;
    rv_r    <= rv_nxt;
    rc_r    <= rc_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

endmodule

`default_nettype wire

// ----- design/line_edit_input_queue_top.sv -----
// ----------------------------------------------------------------------------
// line_edit_input_queue_top
// Canonical line editor in front of a byte ring queue.
// ----------------------------------------------------------------------------
// Input channel (in_*): in_tuser = 0 is a key request carrying in_tdata as
// the character; in_tuser = 1 asks for one byte from the queue. Every request
// gives exactly one response on out_*: tuser[0] echo valid, tuser[1] read
// valid, tdata[7:0] echo char, tdata[15:8] read char (zero when not valid).
// One request is worked on at a time; in_tready is high only while idle.
// Steps: a key that edits the line (or is ignored) goes from decode to the
// finish step; a read passes through one queue RAM read step first; a line
// end first streams the line into the queue one char per cycle through the
// line RAM read port (len = chars buffered, at most LINE_DEPTH-1), then
// pushes LF. out_tvalid and in_tready rise in the same cycle, as the finish
// step posts the response and goes back to idle.
// The response sits in an output register; the block goes idle as soon as
// the response moves there. A stalled receiver holds the next response in
// the finish step until the waiting one is taken.
// Reset (synchronous, rst_n low) empties line and queue by clearing the
// length and the two ring pointers; the RAM contents are left as they are
// and no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module line_edit_input_queue_top #(
  parameter int LINE_DEPTH  = 1024,
  parameter int QUEUE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] key_char
  input  wire logic        in_tuser,   // [0] cmd
  // response channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // [7:0] echo_char, [15:8] read_char
  output logic      [1:0]  out_tuser   // [0] echo_valid, [1] read_valid
);

  import leiq_pkg::*;

  ctrl_cmd_t  cmd;   // sequencer commands
  dp_status_t sts;   // decoded request and pointer status

  leiq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  leiq_dp #(
    .LINE_DEPTH  (LINE_DEPTH),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ----- design/leiq_chk.sv -----
// ----------------------------------------------------------------------------
// leiq_chk
// Port-level checks for the line editor input queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module leiq_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  in_tdata,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  logic in_take;
  assign in_take = in_tvalid && in_tready && (in_tuser || (in_tdata != 8'd0) || 1'b1);

  // stalled response holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled response changed")

  // one request at a time: busy right after an accept
  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_take, !in_tready, "request accepted while busy")

  // a response never both echoes and returns a byte
  `ASSERT_CLK(a_one_kind, clk, rst_n, out_tvalid |-> !(out_tuser[0] && out_tuser[1]), "echo and read in one response")

  // chars are zero when their flag is clear
  `ASSERT_CLK(a_echo_zero, clk, rst_n, (out_tvalid && !out_tuser[0]) |-> (out_tdata[7:0] == 8'd0), "echo char without echo")
  `ASSERT_CLK(a_read_zero, clk, rst_n, (out_tvalid && !out_tuser[1]) |-> (out_tdata[15:8] == 8'd0), "read char without read")

endmodule

bind line_edit_input_queue_top leiq_chk u_leiq_chk (.*);

`default_nettype wire
